// ===== rtl/jlsc_pkg.sv =====
// jlsc_pkg: shared types and constants for the jerk limited stop command block.
// No dependencies.
`default_nettype none

package jlsc_pkg;

    localparam int JLSC_BISECT_STEPS = 32;
    localparam int DIV_W = 56;
    localparam int MUL_W = 32;

    localparam logic [24:0] DT_MIN = 25'd17;
    localparam logic [24:0] DT_MAX = 25'd16777216;

    typedef enum logic [1:0] {
        CFG_STEP_TIME  = 2'd0,
        CFG_ACCEL_LIM  = 2'd1,
        CFG_TURN_LIM   = 2'd2,
        CFG_JERK_LIM   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_INVALID    = 2'd1,
        STAT_INFEASIBLE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_HI  = 2'd0,
        PH_LO  = 2'd1,
        PH_MID = 2'd2
    } phase_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_DELTA,
        S_TURN,
        S_THR,
        U_START,
        U_DIV,
        U_M1,
        U_M2,
        U_M3,
        U_M4,
        S_DECIDE,
        S_BIS,
        S_VEL,
        S_VEL2,
        S_ACC,
        S_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/jlsc_mul.sv =====
// jlsc_mul: registered 32x32 unsigned multiplier shared by the sequencer.
// Depends on jlsc_pkg.
`default_nettype none

module jlsc_mul
    import jlsc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic [MUL_W-1:0]     op_a,
    input  wire logic [MUL_W-1:0]     op_b,
    output logic      [2*MUL_W-1:0]   prod
);

    logic [2*MUL_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/jlsc_div.sv =====
// jlsc_div: restoring divider, one quotient bit per cycle, 56-bit dividend.
// Depends on jlsc_pkg.
`default_nettype none

module jlsc_div
    import jlsc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIV_W-1:0]  dividend,
    input  wire logic [31:0]       divisor,
    output logic                   done,
    output logic      [DIV_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg;
    logic [31:0]      rem_reg;
    logic [31:0]      dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [32:0]      rem_sh;
    logic             ge;
    logic [32:0]      rem_sub;

    assign rem_sh  = {rem_reg, quo_reg[DIV_W-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? rem_sub[31:0] : rem_sh[31:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/jerk_limited_stop_command.sv =====
// jerk_limited_stop_command: top level, config registers and sequencer.
// Depends on jlsc_pkg, jlsc_mul, jlsc_div.
//
//  channel | signals                                        | dir
//  in      | in_valid/in_ready, history_valid, prev_*       | request in
//  out     | out_valid/out_ready, cmd_valid, next_*, status | request out
//  cfg     | cfg_we, cfg_index, cfg_data                    | write only
//
// One request at a time; a command is valid once the request is taken and the serial
// divider and the release tests are done (up to 34 tests with 32 bisection steps).
// Invalid requests answer from the check state, with no divide and no release test;
// infeasible ones answer after the threshold divide or after the first release test.
// Reset returns control to idle and sets config to its default values.
// A stalled result holds in the output registers until out_ready.
`default_nettype none

module jerk_limited_stop_command
    import jlsc_pkg::*;
#(
    parameter int BISECT_STEPS = JLSC_BISECT_STEPS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        history_valid,
    input  wire logic [31:0] prev_velocity,
    input  wire logic [31:0] prev_turn_rate,
    input  wire logic [31:0] prev_accel,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             cmd_valid,
    output logic      [30:0] next_velocity,
    output logic      [31:0] next_turn_rate,
    output logic      [31:0] next_accel,
    output logic      [1:0]  status,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [30:0] cfg_data
);

    localparam int IT_W = $clog2(BISECT_STEPS + 1);

    state_t state_reg, state_next;
    phase_t phase_reg;

    logic [24:0] dt_reg;
    logic [30:0] amax_reg;
    logic [30:0] tlim_reg;
    logic [30:0] jlim_reg;

    logic               hv_reg;
    logic signed [31:0] v_reg;
    logic signed [31:0] w_reg;
    logic signed [31:0] mem_reg;

    logic [31:0]        delta_reg;
    logic signed [33:0] lo_reg;
    logic signed [33:0] hi_reg;
    logic signed [33:0] up_reg;
    logic signed [33:0] ua_reg;
    logic signed [33:0] a_reg;
    logic [55:0]        thr_reg;
    logic [31:0]        m_reg;
    logic [31:0]        c_reg;
    logic [63:0]        p1_reg;
    logic               res_reg;
    logic [IT_W-1:0]    iter_reg;
    logic [30:0]        vn_reg;
    logic               dneg_reg;

    logic        cmd_valid_reg;
    logic [30:0] next_velocity_reg;
    logic [31:0] next_turn_rate_reg;
    logic [31:0] next_accel_reg;
    status_t     status_reg;

    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [2*MUL_W-1:0] mul_p;
    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [31:0]        div_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_q;

    // combinational datapath
    logic               invalid;
    logic signed [33:0] mem_x;
    logic signed [33:0] amax_x;
    logic signed [33:0] lo_raw;
    logic signed [33:0] hi_raw;
    logic signed [33:0] lo_c;
    logic signed [33:0] hi_c;
    logic [32:0]        mw;
    logic [32:0]        dw;
    logic [32:0]        r;
    logic [31:0]        wn;
    logic [31:0]        m_val;
    logic [63:0]        rel;
    logic               mem_big;
    logic signed [33:0] span;
    logic signed [33:0] mid;
    logic               bis_go;
    logic [31:0]        a_mag;
    logic signed [57:0] vsc;
    logic signed [57:0] prodx;
    logic signed [57:0] num;
    logic [33:0]        vsh;
    logic [30:0]        vn_val;
    logic signed [32:0] diff;
    logic [31:0]        mag;
    logic [31:0]        an_val;

    jlsc_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    jlsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign invalid = !hv_reg || (dt_reg < DT_MIN) || (dt_reg > DT_MAX) || (amax_reg == '0)
                     || (tlim_reg == '0) || (jlim_reg == '0) || v_reg[31];

    assign mem_x  = 34'(mem_reg);
    assign amax_x = $signed({3'b000, amax_reg});
    assign lo_raw = mem_x - $signed({2'b00, delta_reg});
    assign hi_raw = mem_x + $signed({2'b00, delta_reg});
    assign lo_c   = (lo_raw < -amax_x) ? -amax_x : lo_raw;
    assign hi_c   = (hi_raw > amax_x) ? amax_x : hi_raw;

    assign mw = w_reg[31] ? 33'(-34'(w_reg)) : {1'b0, w_reg};
    assign dw = {1'b0, mul_p[55:24]};
    assign r  = (mw > dw) ? (mw - dw) : '0;
    assign wn = w_reg[31] ? 32'(-r) : r[31:0];

    assign m_val = 32'(-ua_reg);
    assign rel   = p1_reg - (mul_p >> 1);
    assign mem_big = (mem_reg[31] ? 33'(-34'(mem_reg)) : {1'b0, mem_reg}) > {1'b0, delta_reg};

    assign span   = up_reg - lo_reg;
    assign mid    = lo_reg + (span >>> 1);
    assign bis_go = (32'(iter_reg) < 32'(BISECT_STEPS)) && (span > 34'sd1);

    assign a_mag = a_reg[33] ? 32'(-a_reg) : a_reg[31:0];
    assign vsc   = $signed({3'b000, v_reg[30:0], 24'd0});
    assign prodx = $signed({2'b00, mul_p[55:0]});
    assign num   = a_reg[33] ? (vsc - prodx) : (vsc + prodx);
    assign vsh   = num[57:24];
    assign vn_val = (num[57] || num == '0) ? '0 :
                    ((vsh > 34'h7FFFFFFF) ? 31'h7FFFFFFF : vsh[30:0]);
    assign diff  = $signed({2'b00, vn_val}) - $signed({2'b00, v_reg[30:0]});
    assign mag   = diff[32] ? 32'(-diff) : {1'b0, diff[30:0]};

    always_comb
    begin
        if (dneg_reg)
        begin
            if (div_q > 56'h80000000)
                an_val = 32'h80000000;
            else
                an_val = 32'(-div_q[31:0]);
        end
        else
        begin
            if (div_q > 56'h7FFFFFFF)
                an_val = 32'h7FFFFFFF;
            else
                an_val = div_q[31:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_CHECK;
            S_CHECK:  state_next = invalid ? S_OUT : S_DELTA;
            S_DELTA:  state_next = S_TURN;
            S_TURN:   state_next = S_THR;
            S_THR:
            begin
                if (div_done)
                    state_next = (lo_reg > hi_reg) ? S_OUT : U_START;
            end
            U_START:  state_next = ua_reg[33] ? U_DIV : S_DECIDE;
            U_DIV:    if (div_done) state_next = U_M1;
            U_M1:     state_next = U_M2;
            U_M2:     state_next = U_M3;
            U_M3:     state_next = U_M4;
            U_M4:     state_next = S_DECIDE;
            S_DECIDE:
            begin
                unique case (phase_reg)
                    PH_HI:
                    begin
                        if (res_reg)
                            state_next = S_OUT;
                        else if (v_reg == '0)
                            state_next = mem_big ? S_OUT : S_VEL;
                        else
                            state_next = U_START;
                    end
                    PH_LO:    state_next = res_reg ? S_BIS : S_VEL;
                    PH_MID:   state_next = S_BIS;
                    default:  state_next = S_IDLE;
                endcase
            end
            S_BIS:    state_next = bis_go ? U_START : S_VEL;
            S_VEL:    state_next = S_VEL2;
            S_VEL2:   state_next = S_ACC;
            S_ACC:    if (div_done) state_next = S_OUT;
            S_OUT:    if (out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // unit control
    always_comb
    begin
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        unique case (state_reg)
            S_CHECK:
            begin
                mul_a = {1'b0, jlim_reg};
                mul_b = {7'd0, dt_reg};
            end
            S_DELTA:
            begin
                mul_a = {1'b0, tlim_reg};
                mul_b = {7'd0, dt_reg};
            end
            S_TURN:
            begin
                div_start    = 1'b1;
                div_dividend = {1'b0, v_reg[30:0], 24'd0};
                div_divisor  = {7'd0, dt_reg};
            end
            U_START:
            begin
                div_start    = ua_reg[33];
                div_dividend = DIV_W'({1'b0, m_val} + {1'b0, delta_reg} - 33'd1);
                div_divisor  = delta_reg;
            end
            U_M1:
            begin
                mul_a = c_reg;
                mul_b = m_reg;
            end
            U_M2:
            begin
                mul_a = delta_reg;
                mul_b = c_reg - 32'd1;
            end
            U_M3:
            begin
                mul_a = mul_p[31:0];
                mul_b = c_reg;
            end
            S_VEL:
            begin
                mul_a = a_mag;
                mul_b = {7'd0, dt_reg};
            end
            S_VEL2:
            begin
                div_start    = 1'b1;
                div_dividend = {mag, 24'd0};
                div_divisor  = {7'd0, dt_reg};
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dt_reg    <= 25'd335544;
            amax_reg  <= 31'd1048576;
            tlim_reg  <= 31'd1048576;
            jlim_reg  <= 31'd2097152;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_STEP_TIME: dt_reg   <= cfg_data[24:0];
                    CFG_ACCEL_LIM: amax_reg <= cfg_data;
                    CFG_TURN_LIM:  tlim_reg <= cfg_data;
                    CFG_JERK_LIM:  jlim_reg <= cfg_data;
                    default:       dt_reg   <= dt_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                hv_reg  <= history_valid;
                v_reg   <= prev_velocity;
                w_reg   <= prev_turn_rate;
                mem_reg <= prev_accel;
            end
            S_CHECK:
            begin
                cmd_valid_reg      <= 1'b0;
                next_velocity_reg  <= '0;
                next_turn_rate_reg <= '0;
                next_accel_reg     <= '0;
                status_reg         <= invalid ? STAT_INVALID : STAT_INFEASIBLE;
            end
            S_DELTA:
            begin
                delta_reg <= 32'((mul_p + 64'hFFFFFF) >> 24);
            end
            S_TURN:
            begin
                next_turn_rate_reg <= wn;
                lo_reg <= lo_c;
                hi_reg <= hi_c;
            end
            S_THR:
            begin
                if (div_done)
                begin
                    thr_reg   <= div_q;
                    ua_reg    <= hi_reg;
                    phase_reg <= PH_HI;
                end
            end
            U_START:
            begin
                m_reg <= m_val;
                if (!ua_reg[33])
                    res_reg <= 1'b0;
            end
            U_DIV:
            begin
                if (div_done)
                    c_reg <= div_q[31:0];
            end
            U_M2:
            begin
                p1_reg <= mul_p;
            end
            U_M4:
            begin
                res_reg <= rel > {8'd0, thr_reg};
            end
            S_DECIDE:
            begin
                unique case (phase_reg)
                    PH_HI:
                    begin
                        a_reg     <= '0;
                        ua_reg    <= lo_reg;
                        phase_reg <= PH_LO;
                    end
                    PH_LO:
                    begin
                        a_reg    <= lo_reg;
                        up_reg   <= hi_reg;
                        iter_reg <= '0;
                    end
                    PH_MID:
                    begin
                        if (res_reg)
                            lo_reg <= ua_reg;
                        else
                            up_reg <= ua_reg;
                        iter_reg <= iter_reg + 1'b1;
                    end
                    default:
                    begin
                        iter_reg <= '0;
                    end
                endcase
            end
            S_BIS:
            begin
                a_reg     <= up_reg;
                ua_reg    <= mid;
                phase_reg <= PH_MID;
            end
            S_VEL2:
            begin
                vn_reg   <= vn_val;
                dneg_reg <= diff[32];
            end
            S_ACC:
            begin
                if (div_done)
                begin
                    cmd_valid_reg     <= 1'b1;
                    next_velocity_reg <= vn_reg;
                    next_accel_reg    <= an_val;
                    status_reg        <= STAT_OK;
                end
            end
            default:
            begin
                hv_reg <= hv_reg;
            end
        endcase
        if (state_reg == S_THR && div_done && lo_reg > hi_reg)
            next_turn_rate_reg <= '0;
        if (state_reg == S_DECIDE && phase_reg == PH_HI
            && (res_reg || (v_reg == '0 && mem_big)))
            next_turn_rate_reg <= '0;
    end

    assign cmd_valid      = cmd_valid_reg;
    assign next_velocity  = next_velocity_reg;
    assign next_turn_rate = next_turn_rate_reg;
    assign next_accel     = next_accel_reg;
    assign status         = status_reg;

endmodule

`default_nettype wire
